[hdl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, register indexes, constants and helpers for the pressure
// and temperature compensation datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int W         = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A1_A2,
		REG_A3_A4,
		REG_A5_A6,
		REG_B1_B2,
		REG_MC_MD,
		REG_OSS
	} cfg_reg_t;

	localparam logic [W-1:0] T_OFFSET   = 32'd4000;
	localparam logic [W-1:0] K_SQ       = 32'd3038;
	localparam logic [W-1:0] K_LIN      = 32'd7357;
	localparam logic [W-1:0] K_ROUND    = 32'd3791;
	localparam logic [W-1:0] K_SCALE    = 32'd50000;
	localparam logic [W-1:0] K_HALF     = 32'd32768;
	localparam logic [W-1:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [W-1:0] P_MAX      = 32'd1048575;

	function automatic logic [W-1:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [W-1:0] asr(input logic [W-1:0] x, input logic [4:0] n);
		return W'($signed(x) >>> n);
	endfunction

endpackage

[hdl/psc_div.sv]
// ----------------------------------------------------------------------------
// psc_div
// Unsigned restoring divider, one quotient bit per pipeline stage, with a
// side payload and valid bit travelling alongside each beat.
// ----------------------------------------------------------------------------
module psc_div #(
	parameter int SIDE_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [psc_pkg::W-1:0]  num,
	input  logic [psc_pkg::W-1:0]  den,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_vld,
	output logic [psc_pkg::W-1:0]  quo,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int N = psc_pkg::W;

	logic [N-1:0]      num_s  [1:N];
	logic [N-1:0]      den_s  [1:N];
	logic [N-1:0]      rem_s  [1:N];
	logic [N-1:0]      quo_s  [1:N];
	logic [SIDE_W-1:0] side_s [1:N];
	logic              vld_s  [1:N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N-1:0]      num_c;
		logic [N-1:0]      den_c;
		logic [N-1:0]      rem_c;
		logic [N-1:0]      quo_c;
		logic [SIDE_W-1:0] side_c;
		logic              vld_c;
		logic [N:0]        trial;
		logic [N:0]        diff;
		logic              ge;

		if (k == 0) begin : g_first
			always_comb begin
				num_c  = num;
				den_c  = den;
				rem_c  = '0;
				quo_c  = '0;
				side_c = side_in;
				vld_c  = in_vld;
			end
		end else begin : g_next
			always_comb begin
				num_c  = num_s[k];
				den_c  = den_s[k];
				rem_c  = rem_s[k];
				quo_c  = quo_s[k];
				side_c = side_s[k];
				vld_c  = vld_s[k];
			end
		end

		always_comb begin
			trial = {rem_c, num_c[N-1-k]};
			diff  = trial - {1'b0, den_c};
			ge    = !diff[N];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= num_c;
				den_s[k+1]  <= den_c;
				rem_s[k+1]  <= ge ? diff[N-1:0] : trial[N-1:0];
				quo_s[k+1]  <= {quo_c[N-2:0], ge};
				side_s[k+1] <= side_c;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign quo      = quo_s[N];
	assign side_out = side_s[N];

endmodule

[hdl/pressure_sensor_compensation_core.sv]
// path: s1, s2, divider 1, s3 .. s9, divider 2, s10 .. s12, then outputs
// throughput: one beat per cycle; two 32-stage bit-per-stage dividers set
// the depth, every stage advances together when the output is free
// reset: arst_n clears all valid bits and calibration registers to zero
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_core
// Pipelined barometric compensation: raw temperature and pressure readings
// in, temperature in tenths of a degree and pressure in pascals out.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [15:0]                     raw_temp,
	input  logic [18:0]                     raw_pressure,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [15:0]              temp_tenths,
	output logic [19:0]                     pressure_pa,
	output logic                            div_error
);

	localparam int W   = psc_pkg::W;
	localparam int S1W = W + 19 + 2;
	localparam int S2W = 16 + 2;

	// calibration registers
	logic [31:0] a1a2_q, a3a4_q, a5a6_q, b1b2_q, mcmd_q;
	logic [1:0]  oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1a2_q <= '0;
			a3a4_q <= '0;
			a5a6_q <= '0;
			b1b2_q <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
		end else if (cfg_we) begin
			case (psc_pkg::cfg_reg_t'(cfg_index))
				psc_pkg::REG_A1_A2: a1a2_q <= cfg_data;
				psc_pkg::REG_A3_A4: a3a4_q <= cfg_data;
				psc_pkg::REG_A5_A6: a5a6_q <= cfg_data;
				psc_pkg::REG_B1_B2: b1b2_q <= cfg_data;
				psc_pkg::REG_MC_MD: mcmd_q <= cfg_data;
				psc_pkg::REG_OSS:   oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = psc_pkg::sext16(a1a2_q[31:16]);
	assign ac2 = psc_pkg::sext16(a1a2_q[15:0]);
	assign ac3 = psc_pkg::sext16(a3a4_q[31:16]);
	assign ac4 = {16'd0, a3a4_q[15:0]};
	assign ac5 = {16'd0, a5a6_q[31:16]};
	assign ac6 = {16'd0, a5a6_q[15:0]};
	assign b1  = psc_pkg::sext16(b1b2_q[31:16]);
	assign b2  = psc_pkg::sext16(b1b2_q[15:0]);
	assign mc  = psc_pkg::sext16(mcmd_q[31:16]);
	assign md  = psc_pkg::sext16(mcmd_q[15:0]);

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic d1_vld, d2_vld;

	// s1
	logic [W-1:0] x1m_s1;
	logic [18:0]  up_s1;
	logic [W-1:0] ut_d;
	assign ut_d = (W'(raw_temp) - ac6);

	// s2
	logic [W-1:0] x1_s2, nmag_s2, dmag_s2;
	logic         neg_s2, err_s2;
	logic [18:0]  up_s2;
	logic [W-1:0] x1_c, dv_c, nm_c;
	assign x1_c = psc_pkg::asr(x1m_s1, 5'd15);
	assign dv_c = x1_c + md;
	assign nm_c = mc << 11;

	// divider 1
	logic [W-1:0]   q1;
	logic [S1W-1:0] side1;
	logic [W-1:0]   d1_x1;
	logic [18:0]    d1_up;
	logic           d1_neg, d1_err;
	assign {d1_x1, d1_up, d1_neg, d1_err} = side1;

	psc_div #(.SIDE_W(S1W)) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (v_s2),
		.num      (nmag_s2),
		.den      (dmag_s2),
		.side_in  ({x1_s2, up_s2, neg_s2, err_s2}),
		.out_vld  (d1_vld),
		.quo      (q1),
		.side_out (side1)
	);

	// s3 .. s9
	logic [W-1:0] b5_s3, b6_s4;
	logic [18:0]  up_s3, up_s4, up_s5, up_s6, up_s7, up_s8;
	logic         err_s3, err_s4, err_s5, err_s6, err_s7, err_s8, err_s9;
	logic [15:0]  t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;
	logic [W-1:0] sqp_s5, m1_s5, m2_s5;
	logic [W-1:0] p1_s6, p2_s6, x2a_s6, x1c_s6;
	logic [W-1:0] b3p_s7, x3b_s7;
	logic [W-1:0] b3_s8, b4m_s8;
	logic [W-1:0] b4_s9, b7_s9;

	logic [W-1:0] q1_sgn, tv_c, sq_c, b3_c, x3b_c, b4_c;
	logic [15:0]  tsat_c;
	assign q1_sgn = d1_neg ? (W'(0) - q1) : q1;
	assign tv_c   = psc_pkg::asr(b5_s3 + 32'd8, 5'd4);
	always_comb begin
		if ($signed(tv_c) > 32'sd32767) begin
			tsat_c = 16'h7FFF;
		end else if ($signed(tv_c) < -32'sd32768) begin
			tsat_c = 16'h8000;
		end else begin
			tsat_c = tv_c[15:0];
		end
	end
	assign sq_c  = psc_pkg::asr(sqp_s5, 5'd12);
	assign x3b_c = psc_pkg::asr(x1c_s6 + psc_pkg::asr(p2_s6, 5'd16) + 32'd2, 5'd2);
	assign b3_c  = psc_pkg::asr((b3p_s7 << oss_q) + 32'd2, 5'd2);
	assign b4_c  = b4m_s8 >> 15;

	// divider 2
	logic [W-1:0]   q2;
	logic [S2W-1:0] side2;
	logic [15:0]    d2_t;
	logic           d2_hi, d2_err;
	assign {d2_t, d2_hi, d2_err} = side2;

	psc_div #(.SIDE_W(S2W)) u_div_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (v_s9),
		.num      (b7_s9[W-1] ? b7_s9 : (b7_s9 << 1)),
		.den      (b4_s9),
		.side_in  ({t_s9, b7_s9[W-1], err_s9}),
		.out_vld  (d2_vld),
		.quo      (q2),
		.side_out (side2)
	);

	// s10 .. s12 and output stage
	logic [W-1:0] p_s10, p_s11, p_s12, sqr_s11, m7_s11, x1m_s12, x2_s12;
	logic [15:0]  t_s10, t_s11, t_s12;
	logic         err_s10, err_s11, err_s12;
	logic [W-1:0] pa_c, pf_c;
	logic [19:0]  psat_c;
	assign pa_c = psc_pkg::asr(p_s10, 5'd8);
	assign pf_c = p_s12 + psc_pkg::asr(psc_pkg::asr(x1m_s12, 5'd16) + x2_s12
		+ psc_pkg::K_ROUND, 5'd4);
	always_comb begin
		if (pf_c[W-1]) begin
			psat_c = '0;
		end else if (pf_c > psc_pkg::P_MAX) begin
			psat_c = '1;
		end else begin
			psat_c = pf_c[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			v_s11     <= 1'b0;
			v_s12     <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= d1_vld;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= d2_vld;
			v_s11     <= v_s10;
			v_s12     <= v_s11;
			out_valid <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1m_s1  <= ut_d * ac5;
			up_s1   <= raw_pressure;

			x1_s2   <= x1_c;
			up_s2   <= up_s1;
			err_s2  <= (dv_c == '0);
			neg_s2  <= nm_c[W-1] ^ dv_c[W-1];
			nmag_s2 <= nm_c[W-1] ? (W'(0) - nm_c) : nm_c;
			dmag_s2 <= dv_c[W-1] ? (W'(0) - dv_c) : dv_c;

			b5_s3   <= d1_x1 + q1_sgn;
			up_s3   <= d1_up;
			err_s3  <= d1_err;

			b6_s4   <= b5_s3 - psc_pkg::T_OFFSET;
			t_s4    <= tsat_c;
			up_s4   <= up_s3;
			err_s4  <= err_s3;

			sqp_s5  <= b6_s4 * b6_s4;
			m1_s5   <= ac2 * b6_s4;
			m2_s5   <= ac3 * b6_s4;
			t_s5    <= t_s4;
			up_s5   <= up_s4;
			err_s5  <= err_s4;

			p1_s6   <= b2 * sq_c;
			p2_s6   <= b1 * sq_c;
			x2a_s6  <= psc_pkg::asr(m1_s5, 5'd11);
			x1c_s6  <= psc_pkg::asr(m2_s5, 5'd13);
			t_s6    <= t_s5;
			up_s6   <= up_s5;
			err_s6  <= err_s5;

			b3p_s7  <= (ac1 << 2) + psc_pkg::asr(p1_s6, 5'd11) + x2a_s6;
			x3b_s7  <= x3b_c;
			t_s7    <= t_s6;
			up_s7   <= up_s6;
			err_s7  <= err_s6;

			b3_s8   <= b3_c;
			b4m_s8  <= ac4 * (x3b_s7 + psc_pkg::K_HALF);
			t_s8    <= t_s7;
			up_s8   <= up_s7;
			err_s8  <= err_s7;

			b4_s9   <= b4_c;
			b7_s9   <= (W'(up_s8) - b3_s8) * (psc_pkg::K_SCALE >> oss_q);
			t_s9    <= t_s8;
			err_s9  <= err_s8 || (b4_c == '0);

			p_s10   <= d2_hi ? (q2 << 1) : q2;
			t_s10   <= d2_t;
			err_s10 <= d2_err;

			sqr_s11 <= pa_c * pa_c;
			m7_s11  <= psc_pkg::K_LIN * p_s10;
			p_s11   <= p_s10;
			t_s11   <= t_s10;
			err_s11 <= err_s10;

			x1m_s12 <= sqr_s11 * psc_pkg::K_SQ;
			x2_s12  <= psc_pkg::asr(W'(0) - m7_s11, 5'd16);
			p_s12   <= p_s11;
			t_s12   <= t_s11;
			err_s12 <= err_s11;

			temp_tenths <= err_s12 ? 16'sd0 : $signed(t_s12);
			pressure_pa <= err_s12 ? 20'd0 : psat_c;
			div_error   <= err_s12;
		end
	end

endmodule

[hdl/psc_checker.sv]
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks on the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
module psc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] temp_tenths,
	input logic [19:0] pressure_pa,
	input logic        div_error
);

	// a held result beat keeps its pressure and error flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_pa) && $stable(div_error))
		else $error("held result beat changed");

	// an error beat carries zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |-> temp_tenths == 16'd0 && pressure_pa == 20'd0)
		else $error("error beat with non-zero results");

	// input is only held back by a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind pressure_sensor_compensation_core psc_checker u_psc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.temp_tenths (temp_tenths),
	.pressure_pa (pressure_pa),
	.div_error   (div_error)
);
